// ----- hw/rtl/lru_kv_pkg.sv -----
`timescale 1ns / 1ps

package lru_kv_pkg;

  // Widths of the item fields on the ports.
  localparam int unsigned KeyPortW   = 32;
  localparam int unsigned ValuePortW = 32;
  localparam int unsigned CapW       = 5;

  // Default sizing of the table.
  localparam int unsigned DefEntries    = 16;
  localparam int unsigned DefKeyWidth   = 32;
  localparam int unsigned DefValueWidth = 32;

  // Capacity register value after reset.
  localparam logic [CapW-1:0] CapReset = 5'd16;

  // Action codes of an input item.
  localparam logic [1:0] ActLookup = 2'd0;
  localparam logic [1:0] ActInsert = 2'd1;
  localparam logic [1:0] ActFlush  = 2'd2;

  // Control from the tag array to the value store and result stage.
  typedef struct packed {
    logic hit;    // key was present on a lookup or insert
    logic rd_en;  // lookup hit: read the value at the slot
    logic wr_en;  // insert: write the value at the slot
  } lru_kv_ctl_t;

endpackage

// ----- hw/rtl/lru_key_value_cache_top.sv -----
`timescale 1ns / 1ps

// An accepted item is captured in the input register, handled by the tag
// array and strobed on done_o from the result register.
// Throughput: one item per cycle; busy stays low since the single compare
// and update stage never holds an item back. Reset clears the valid
// bits, ages, entry count and pipeline strobes at once and sets the
// capacity to 16; there is no clearing pass. The receiver cannot stall.
module lru_key_value_cache_top
  import lru_kv_pkg::*;
#(
  parameter int unsigned ENTRIES     = DefEntries,
  parameter int unsigned KEY_WIDTH   = DefKeyWidth,
  parameter int unsigned VALUE_WIDTH = DefValueWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CapW-1:0]       cfg_wdata_i,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            action_i,
  input  logic [KeyPortW-1:0]   key_i,
  input  logic [ValuePortW-1:0] value_i,
  output logic                  done_o,
  output logic                  hit_o,
  output logic [ValuePortW-1:0] read_value_o
);

  // Only the low bits of the key and value ports that fit the table are kept.
  localparam int unsigned KW = (KEY_WIDTH < KeyPortW) ? KEY_WIDTH : KeyPortW;
  localparam int unsigned VW = (VALUE_WIDTH < ValuePortW) ? VALUE_WIDTH : ValuePortW;
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [CapW-1:0] cap_q;
  logic            vld_q;
  logic [1:0]      act_q;
  logic [KW-1:0]   key_q;
  logic [VW-1:0]   val_q;
  logic            done_q, hit_q, rdsel_q;

  lru_kv_ctl_t     ctl;
  logic [IW-1:0]   slot;
  logic [VW-1:0]   ram_rdata;

  // busy is tied low, so the block never holds off start.
  assign busy = 1'b0;

  // Capacity register; the user is to write it only while the block is idle, the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Input register. The item is taken whenever start is high.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      act_q <= action_i;
      key_q <= key_i[KW-1:0];
      val_q <= value_i[VW-1:0];
    end
  end

  // Tag array: parallel key compare, age ranks, valid bits and entry count.
  // It picks the slot that is hit, or the slot a new key goes to.
  lru_kv_tag #(
    .ENTRIES (ENTRIES),
    .KW      (KW),
    .IW      (IW)
  ) u_tag (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld_q),
    .act_i  (act_q),
    .key_i  (key_q),
    .cap_i  (cap_q),
    .ctl_o  (ctl),
    .slot_o (slot)
  );

  // Value store. A lookup hit reads the slot in the same cycle that the
  // result strobe is registered, so the registered read data lines up with
  // done_o. Inserts write here and never read, so no bypass is needed.
  lru_kv_ram #(
    .WIDTH (VW),
    .DEPTH (ENTRIES),
    .AW    (IW)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (ctl.wr_en),
    .waddr_i (slot),
    .wdata_i (val_q),
    .re_i    (ctl.rd_en),
    .raddr_i (slot),
    .rdata_o (ram_rdata)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
      rdsel_q <= 1'b0;
    end else begin
      done_q  <= vld_q;
      hit_q   <= ctl.hit;
      rdsel_q <= ctl.rd_en;
    end
  end

  assign done_o       = done_q;
  assign hit_o        = hit_q;
  assign read_value_o = rdsel_q ? ValuePortW'(ram_rdata) : '0;

endmodule

// ----- hw/rtl/lru_kv_ram.sv -----
`timescale 1ns / 1ps

module lru_kv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/lru_kv_tag.sv -----
`timescale 1ns / 1ps

module lru_kv_tag
  import lru_kv_pkg::*;
#(
  parameter int unsigned ENTRIES = DefEntries,
  parameter int unsigned KW      = DefKeyWidth,
  parameter int unsigned IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  logic [1:0]      act_i,
  input  logic [KW-1:0]   key_i,
  input  logic [CapW-1:0] cap_i,
  output lru_kv_ctl_t     ctl_o,
  output logic [IW-1:0]   slot_o
);

  localparam int unsigned AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(ENTRIES + 1);
  localparam int unsigned CMPW = (CW > CapW) ? CW : CapW;

  logic [KW-1:0]  key_q   [ENTRIES];
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [AW-1:0]  age_q   [ENTRIES];
  logic [AW-1:0]  age_d   [ENTRIES];
  logic [CW-1:0]  count_q, count_d;

  logic [ENTRIES-1:0] match, oldest, free, sel;
  logic           hit_any, full, evict, found;
  logic           is_lookup, is_insert, is_flush;
  logic [IW-1:0]  hit_slot, free_slot;
  logic [AW-1:0]  hit_age, last_age;

  assign is_lookup = vld_i && (act_i == ActLookup);
  assign is_insert = vld_i && (act_i == ActInsert);
  assign is_flush  = vld_i && (act_i == ActFlush);

  // Ages of valid entries run from 0 to count-1, so the least recent one
  // is the entry whose age equals count-1.
  assign last_age = AW'(count_q - CW'(1));

  always_comb begin
    hit_slot = '0;
    hit_age  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_q[i] && (key_q[i] == key_i);
      oldest[i] = valid_q[i] && (age_q[i] == last_age);
      if (match[i]) begin
        hit_slot = hit_slot | IW'(i);
        hit_age  = hit_age | age_q[i];
      end
    end
  end

  assign hit_any = |match;
  assign full    = (count_q != '0) &&
                   ((CMPW'(count_q) >= CMPW'(cap_i)) || (count_q == CW'(ENTRIES)));
  assign evict   = is_insert && !hit_any && full;

  always_comb begin
    free_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      free[i] = !valid_q[i] || (evict && oldest[i]);
      if (free[i]) begin
        free_slot = IW'(i);
      end
    end
  end

  assign found = |free;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      sel[i] = found && (free_slot == IW'(i));
    end
  end

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    for (int i = 0; i < ENTRIES; i++) begin
      age_d[i] = age_q[i];
    end
    if ((is_lookup || is_insert) && hit_any) begin
      // Move the hit entry to the front; younger entries age by one.
      for (int i = 0; i < ENTRIES; i++) begin
        if (match[i]) begin
          age_d[i] = '0;
        end else if (valid_q[i] && (age_q[i] < hit_age)) begin
          age_d[i] = AW'(age_q[i] + AW'(1));
        end
      end
    end else if (is_insert) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_d[i] = valid_q[i] && !(evict && oldest[i]);
        if (sel[i]) begin
          valid_d[i] = 1'b1;
          age_d[i]   = '0;
        end else if (valid_d[i]) begin
          age_d[i] = AW'(age_q[i] + AW'(1));
        end
      end
      count_d = CW'(count_q - CW'(evict) + CW'(found));
    end else if (is_flush) begin
      valid_d = '0;
      count_d = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= age_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (is_insert && !hit_any && sel[i]) begin
        key_q[i] <= key_i;
      end
    end
  end

  assign ctl_o.hit   = (is_lookup || is_insert) && hit_any;
  assign ctl_o.rd_en = is_lookup && hit_any;
  assign ctl_o.wr_en = is_insert && (hit_any || found);
  assign slot_o      = hit_any ? hit_slot : free_slot;

endmodule

// ----- hw/rtl/lru_kv_checker.sv -----
`timescale 1ns / 1ps

module lru_kv_checker
  import lru_kv_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input logic [1:0]            action_i,
  input logic                  done_o,
  input logic                  hit_o,
  input logic [ValuePortW-1:0] read_value_o
);

  // Every accepted item gives its result through the input and result registers.
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && rst_ni) |=> ##1 done_o)
    else $error("accepted item produced no result");

  // No result appears without an item accepted before it.
  a_latency_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy && rst_ni, 2))
    else $error("result strobe without an accepted item");

  // A value is only shown for a hit.
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!done_o || !hit_o) |-> (read_value_o == '0))
    else $error("nonzero read value without a hit");

  // A lookup right after a flush must miss.
  a_flush_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && rst_ni && (action_i == ActFlush)) ##1
    (start && !busy && (action_i == ActLookup)) |=> ##1 (done_o && !hit_o))
    else $error("lookup hit after a flush");

endmodule

bind lru_key_value_cache_top lru_kv_checker u_lru_kv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .action_i     (action_i),
  .done_o       (done_o),
  .hit_o        (hit_o),
  .read_value_o (read_value_o)
);

// ----- tb/lru_key_value_cache_checker.sv -----
`timescale 1ns / 1ps

module lru_key_value_cache_checker
  import lru_kv_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CapW-1:0]       cfg_wdata_i,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic [1:0]            action_i,
  input  logic [KeyPortW-1:0]   key_i,
  input  logic [ValuePortW-1:0] value_i,
  input  logic                  done_i,
  input  logic                  hit_i,
  input  logic [ValuePortW-1:0] read_value_i,
  output int unsigned           error_count_o,
  output int unsigned           pending_o
);

  localparam int unsigned Slots = DefEntries;

  typedef struct packed {
    logic                  hit;
    logic [ValuePortW-1:0] read_value;
  } cache_reply_t;

  logic [KeyPortW-1:0]   slot_key   [Slots];
  logic [ValuePortW-1:0] slot_value [Slots];
  bit                    slot_valid [Slots];
  int unsigned           slot_age   [Slots];
  int unsigned           live_count;
  logic [CapW-1:0]       capacity;
  cache_reply_t          reply_q [$];

  function automatic int find_slot(input logic [KeyPortW-1:0] k);
    for (int i = 0; i < Slots; i++) begin
      if (slot_valid[i] && slot_key[i] == k) return i;
    end
    return -1;
  endfunction

  // Entries younger than slot s age by one; s becomes the newest.
  function automatic void make_newest(input int s);
    int unsigned a;
    a = slot_age[s];
    for (int i = 0; i < Slots; i++) begin
      if (slot_valid[i] && slot_age[i] < a) slot_age[i]++;
    end
    slot_age[s] = 0;
  endfunction

  function automatic cache_reply_t cache_apply(input logic [1:0]            act,
                                               input logic [KeyPortW-1:0]   k,
                                               input logic [ValuePortW-1:0] v);
    cache_reply_t r;
    int           s;
    int           oldest;
    int unsigned  limit;
    r = '0;
    case (act)
      ActLookup: begin
        s = find_slot(k);
        if (s >= 0) begin
          r.hit        = 1'b1;
          r.read_value = slot_value[s];
          make_newest(s);
        end
      end
      ActInsert: begin
        s = find_slot(k);
        if (s >= 0) begin
          r.hit         = 1'b1;
          slot_value[s] = v;
          make_newest(s);
        end else begin
          limit = (capacity > Slots) ? Slots : capacity;
          // Only the single oldest entry goes, even if the count is above the limit.
          if (live_count > 0 && live_count >= limit) begin
            oldest = -1;
            for (int i = 0; i < Slots; i++) begin
              if (slot_valid[i] && (oldest < 0 || slot_age[i] > slot_age[oldest])) oldest = i;
            end
            if (oldest >= 0) begin
              slot_valid[oldest] = 1'b0;
              live_count--;
            end
          end
          s = -1;
          for (int i = 0; i < Slots; i++) begin
            if (!slot_valid[i] && s < 0) s = i;
          end
          if (s >= 0) begin
            for (int i = 0; i < Slots; i++) begin
              if (slot_valid[i]) slot_age[i]++;
            end
            slot_valid[s] = 1'b1;
            slot_key[s]   = k;
            slot_value[s] = v;
            slot_age[s]   = 0;
            live_count++;
          end
        end
      end
      ActFlush: begin
        for (int i = 0; i < Slots; i++) begin
          slot_valid[i] = 1'b0;
          slot_age[i]   = 0;
        end
        live_count = 0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cache_reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        slot_key[i]   = '0;
        slot_value[i] = '0;
        slot_valid[i] = 1'b0;
        slot_age[i]   = 0;
      end
      live_count    = 0;
      capacity      = CapReset;
      reply_q.delete();
      error_count_o = 0;
      pending_o     = 0;
    end else begin
      if (done_i) begin
        if (reply_q.size() == 0) begin
          $error("result strobed with no item outstanding: hit %0d read_value 0x%08h",
                 hit_i, read_value_i);
          error_count_o++;
        end else begin
          want = reply_q.pop_front();
          if (hit_i !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, hit_i);
            error_count_o++;
          end
          if (read_value_i !== want.read_value) begin
            $error("read_value: expected 0x%08h, actual 0x%08h", want.read_value, read_value_i);
            error_count_o++;
          end
        end
      end
      if (start_i && !busy_i) reply_q.push_back(cache_apply(action_i, key_i, value_i));
      if (cfg_we_i) capacity = cfg_wdata_i;
      pending_o = reply_q.size();
    end
  end

endmodule

// ----- tb/lru_key_value_cache_top_test.sv -----
`timescale 1ns / 1ps

module lru_key_value_cache_top_test;
  import lru_kv_pkg::*;

  // The block ignores action code 3; it still answers with a miss.
  localparam logic [1:0] ActUnknown = 2'd3;

  localparam int unsigned PhaseItems = 85;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CapW-1:0]       cfg_wdata;
  logic                  start;
  logic                  busy;
  logic [1:0]            action;
  logic [KeyPortW-1:0]   key;
  logic [ValuePortW-1:0] wdata;
  logic                  done;
  logic                  hit;
  logic [ValuePortW-1:0] read_value;
  int unsigned           error_count;
  int unsigned           pending;
  bit                    no_gaps;

  lru_key_value_cache_top i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .start        (start),
    .busy         (busy),
    .action_i     (action),
    .key_i        (key),
    .value_i      (wdata),
    .done_o       (done),
    .hit_o        (hit),
    .read_value_o (read_value)
  );

  // The checker sees the same pins as the block, keeps its own copy of the
  // table and compares every strobed result against the oldest prediction.
  lru_key_value_cache_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .start_i       (start),
    .busy_i        (busy),
    .action_i      (action),
    .key_i         (key),
    .value_i       (wdata),
    .done_i        (done),
    .hit_i         (hit),
    .read_value_i  (read_value),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case a handshake never completes or a result never shows up.
  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  // Offers one item and returns at the falling edge after it was taken.
  // Every call starts on a falling edge, so all inputs change away from the
  // sampling edge. With a zero gap start simply stays high, which gives
  // back-to-back items.
  task automatic issue_request(input logic [1:0]            act,
                               input logic [KeyPortW-1:0]   k,
                               input logic [ValuePortW-1:0] v);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    action <= act;
    key    <= k;
    wdata  <= v;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Drops start and waits until every predicted result has been strobed.
  // Since every item yields exactly one result, the block is idle then.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] cap);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random phase: a fresh capacity and a small pool of keys, so lookups
  // and inserts hit often enough to exercise the age ranking, while a few
  // fully random keys keep misses and evictions coming.
  task automatic run_phase(input logic [CapW-1:0] cap, input bit steady);
    logic [KeyPortW-1:0] pool [24];
    int unsigned         pool_size;
    int unsigned         roll;
    logic [1:0]          act;
    logic [KeyPortW-1:0] k;
    write_capacity(cap);
    no_gaps   = steady;
    pool_size = $urandom_range(2, 24);
    for (int i = 0; i < 24; i++) pool[i] = $urandom();
    pool[0] = '0;
    pool[1] = '1;
    for (int n = 0; n < PhaseItems; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        act = ActLookup;
      end else if (roll < 94) begin
        act = ActInsert;
      end else if (roll < 97) begin
        act = ActFlush;
      end else begin
        act = ActUnknown;
      end
      if ($urandom_range(0, 9) == 0) begin
        k = $urandom();
      end else begin
        k = pool[$urandom_range(0, pool_size - 1)];
      end
      issue_request(act, k, $urandom());
    end
  endtask

  initial begin
    logic [CapW-1:0] phase_cap [8];
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    start     = 1'b0;
    action    = ActLookup;
    key       = '0;
    wdata     = '0;
    no_gaps   = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part at the reset capacity: a miss on the empty table, the
    // all-zero and all-one keys and values, an update of a present key, an
    // ignored action code and a flush.
    issue_request(ActLookup, '0, 32'h1234_5678);
    issue_request(ActInsert, '0, '0);
    issue_request(ActInsert, '1, '1);
    issue_request(ActLookup, '0, '0);
    issue_request(ActLookup, '1, '0);
    issue_request(ActInsert, '0, 32'h5A5A_A5A5);
    issue_request(ActLookup, '0, '1);
    issue_request(ActUnknown, '0, '1);
    issue_request(ActLookup, '0, '0);
    issue_request(ActFlush, '1, '1);
    issue_request(ActLookup, '1, '0);

    // A capacity of two: the lookup of key 1 makes key 2 the oldest, so the
    // insert of key 3 must evict key 2 and leave key 1 in place.
    write_capacity(5'd2);
    issue_request(ActInsert, 32'd1, 32'd11);
    issue_request(ActInsert, 32'd2, 32'd22);
    issue_request(ActLookup, 32'd1, '0);
    issue_request(ActInsert, 32'd3, 32'd33);
    issue_request(ActLookup, 32'd2, '0);
    issue_request(ActLookup, 32'd1, '0);

    // Capacity zero with two entries held: each new key evicts only one.
    write_capacity(5'd0);
    issue_request(ActInsert, 32'd4, 32'd44);
    issue_request(ActInsert, 32'd5, 32'd55);
    issue_request(ActLookup, 32'd4, '0);

    // A capacity above the table size is clipped to the table size.
    write_capacity(5'd31);
    issue_request(ActInsert, 32'd6, 32'd66);
    issue_request(ActLookup, 32'd5, '0);

    // Random phases. A full table at 16 followed by a capacity of 1 covers
    // lowering the capacity below the number of stored entries. Some phases
    // run without gaps so back-to-back items meet every stage of the block.
    phase_cap[0] = 5'd16;
    phase_cap[1] = 5'd1;
    phase_cap[2] = 5'd0;
    phase_cap[3] = 5'd31;
    phase_cap[4] = 5'd5;
    phase_cap[5] = 5'd17;
    phase_cap[6] = 5'd2;
    phase_cap[7] = CapW'($urandom_range(1, 16));
    for (int ph = 0; ph < 8; ph++) begin
      run_phase(phase_cap[ph], (ph % 3) == 1);
    end

    // Let the last results drain, then give the block a few more cycles in
    // case it strobes anything it should not.
    wait_idle();
    repeat (4) @(negedge clk);

    if (error_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/lru_kv_pkg.sv
hw/rtl/lru_kv_ram.sv
hw/rtl/lru_kv_tag.sv
hw/rtl/lru_key_value_cache_top.sv
hw/rtl/lru_kv_checker.sv
tb/lru_key_value_cache_checker.sv
tb/lru_key_value_cache_top_test.sv
